// ===== rtl/rpv_pkg.sv =====
// shared constants, types and sine table for the vertex rotate and project unit
package rpv_pkg;

  // number formats
  localparam int unsigned FracBits    = 8;
  localparam int unsigned TrigBits    = 14;
  localparam int unsigned HalfCircle  = 180;
  localparam int unsigned QuarterTurn = HalfCircle / 2;
  localparam int unsigned FullCircle  = 2 * HalfCircle;

  // field widths
  localparam int unsigned AngleW   = 9;
  localparam int unsigned DistW    = 24;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned VertW    = 16;
  localparam int unsigned OutW     = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = DistW;

  // datapath widths
  localparam int unsigned TableW = TrigBits + 1;
  localparam int unsigned TrigW  = TrigBits + 2;
  localparam int unsigned IdxW   = $clog2(QuarterTurn + 1);
  localparam int unsigned CoordW = 20;
  localparam int unsigned MagW   = CoordW;
  localparam int unsigned ProdW  = CoordW + TrigW;
  localparam int unsigned PW     = 2 * ScaleW;
  localparam int unsigned VdW    = MagW + DistW;
  localparam int unsigned VdLoW  = VdW / 2;
  localparam int unsigned VdHiW  = VdW - VdLoW;
  localparam int unsigned NumW   = VdW + PW;
  localparam int unsigned DenW   =
    ((CoordW + PW > DistW + 2 * FracBits) ? CoordW + PW : DistW + 2 * FracBits) + 1;
  localparam int unsigned QuotW  = OutW + 1;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANGLE_X      = 3'd0,
    CFG_ANGLE_Y      = 3'd1,
    CFG_ANGLE_Z      = 3'd2,
    CFG_OBSERVER     = 3'd3,
    CFG_SCALE        = 3'd4,
    CFG_SPACE_LENGTH = 3'd5
  } cfg_reg_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SAT      = 2'd1,
    STATUS_ZERO_DEN = 2'd2
  } status_e;

  // products handed from a projection to its divider
  typedef struct packed {
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic [DenW-1:0] den;
    logic            neg_x;
    logic            neg_y;
    logic            zero;
  } proj_t;

  // divider results
  typedef struct packed {
    logic [OutW-1:0] res_x;
    logic [OutW-1:0] res_y;
    logic            sat;
    logic            zero;
  } div_res_t;

  // quarter-wave sine, Q1.14
  localparam logic [TableW-1:0] QuarterSine [QuarterTurn+1] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240,
    15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402,
    15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438,
    15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
    15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
    15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082,
    15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
    15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182,
    15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
    15'd16382, 15'd16384
  };

  // fold angles 360..511 back into one turn
  function automatic logic [AngleW-1:0] norm_angle(input logic [AngleW-1:0] a);
    return (a >= AngleW'(FullCircle)) ? AngleW'(a - AngleW'(FullCircle)) : a;
  endfunction

  // sine from the quarter table by quadrant
  function automatic logic signed [TrigW-1:0] sine_of(input logic [AngleW-1:0] a);
    logic [AngleW-1:0]       n;
    logic [AngleW-1:0]       i;
    logic                    neg;
    logic signed [TrigW-1:0] mag;
    n = norm_angle(a);
    priority if (n <= AngleW'(QuarterTurn)) begin
      i   = n;
      neg = 1'b0;
    end else if (n <= AngleW'(HalfCircle)) begin
      i   = AngleW'(AngleW'(HalfCircle) - n);
      neg = 1'b0;
    end else if (n <= AngleW'(HalfCircle + QuarterTurn)) begin
      i   = AngleW'(n - AngleW'(HalfCircle));
      neg = 1'b1;
    end else begin
      i   = AngleW'(AngleW'(FullCircle) - n);
      neg = 1'b1;
    end
    mag = $signed(TrigW'(QuarterSine[i[IdxW-1:0]]));
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [TrigW-1:0] cosine_of(input logic [AngleW-1:0] a);
    return sine_of(AngleW'(norm_angle(a) + AngleW'(QuarterTurn)));
  endfunction

endpackage

// ===== rtl/rpv_rot_pair.sv =====
// two-stage plane rotation of one coordinate pair, Q1.14 coefficients
module rpv_rot_pair import rpv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] a_i,
  input  logic signed [CoordW-1:0] b_i,
  input  logic signed [CoordW-1:0] pass_i,
  input  logic signed [TrigW-1:0]  cos_i,
  input  logic signed [TrigW-1:0]  sin_i,
  output logic                     valid_o,
  output logic signed [CoordW-1:0] a_o,
  output logic signed [CoordW-1:0] b_o,
  output logic signed [CoordW-1:0] pass_o
);

  localparam int unsigned SumW = ProdW + 1;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) << (TrigBits - 1);

  logic                     vld1_q, vld2_q;
  logic signed [ProdW-1:0]  ac_d, bs_d, bc_d, as_d;
  logic signed [ProdW-1:0]  ac_q, bs_q, bc_q, as_q;
  logic signed [CoordW-1:0] pass1_q, pass2_q;
  logic signed [SumW-1:0]   sum_a, sum_b;
  logic signed [CoordW-1:0] a_d, b_d, a_q, b_q;

  // stage 1: the four products
  always_comb begin
    ac_d = ProdW'(a_i) * ProdW'(cos_i);
    bs_d = ProdW'(b_i) * ProdW'(sin_i);
    bc_d = ProdW'(b_i) * ProdW'(cos_i);
    as_d = ProdW'(a_i) * ProdW'(sin_i);
  end

  // stage 2: sums, round half up and floor shift
  always_comb begin
    sum_a = SumW'(ac_q) - SumW'(bs_q) + RoundHalf;
    sum_b = SumW'(bc_q) + SumW'(as_q) + RoundHalf;
    a_d   = CoordW'(sum_a >>> TrigBits);
    b_d   = CoordW'(sum_b >>> TrigBits);
  end

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // data pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q    <= ac_d;
      bs_q    <= bs_d;
      bc_q    <= bc_d;
      as_q    <= as_d;
      pass1_q <= pass_i;
      a_q     <= a_d;
      b_q     <= b_d;
      pass2_q <= pass1_q;
    end
  end

  assign valid_o = vld2_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign pass_o  = pass2_q;

endmodule

// ===== rtl/rpv_project.sv =====
// four-stage numerator and denominator products of one perspective projection
module rpv_project import rpv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  input  logic signed [CoordW-1:0] z_i,
  input  logic [DistW-1:0]         dist_i,
  input  logic [PW-1:0]            scale_i,
  output logic                     valid_o,
  output proj_t                    proj_o
);

  localparam int unsigned ZpW  = CoordW + PW + 1;
  localparam int unsigned DShW = 2 * FracBits;
  localparam int unsigned LoW  = VdLoW + PW;
  localparam int unsigned HiW  = VdHiW + PW;

  logic [3:0] vld_q;

  // stage 1
  logic [MagW-1:0]       magx_d, magy_d, magx_q, magy_q;
  logic                  posx_d, posy_d, posx1_q, posy1_q;
  logic signed [ZpW-1:0] zp_d, zp_q;
  // stage 2
  logic [VdW-1:0]         vdx_d, vdy_d, vdx_q, vdy_q;
  logic signed [DenW-1:0] den_d, den_q;
  logic                   posx2_q, posy2_q;
  // stage 3
  logic [LoW-1:0]  lox_d, loy_d, lox_q, loy_q;
  logic [HiW-1:0]  hix_d, hiy_d, hix_q, hiy_q;
  logic [DenW-1:0] dmag_d, dmag_q;
  logic            dneg_q, zero_q, posx3_q, posy3_q;
  // stage 4
  proj_t proj_d, proj_q;

  // stage 1: magnitudes, signs and z times scale
  always_comb begin
    magx_d = MagW'(x_i[CoordW-1] ? -x_i : x_i);
    magy_d = MagW'(y_i[CoordW-1] ? -y_i : y_i);
    posx_d = !x_i[CoordW-1] && (x_i != '0);
    posy_d = !y_i[CoordW-1] && (y_i != '0);
    zp_d   = ZpW'(z_i) * $signed({1'b0, scale_i});
  end

  // stage 2: value times distance, denominator
  always_comb begin
    vdx_d = VdW'(magx_q) * VdW'(dist_i);
    vdy_d = VdW'(magy_q) * VdW'(dist_i);
    den_d = DenW'(zp_q) - $signed(DenW'({dist_i, DShW'(0)}));
  end

  // stage 3: split products with the scale, denominator magnitude
  always_comb begin
    lox_d  = LoW'(vdx_q[VdLoW-1:0]) * LoW'(scale_i);
    loy_d  = LoW'(vdy_q[VdLoW-1:0]) * LoW'(scale_i);
    hix_d  = HiW'(vdx_q[VdW-1:VdLoW]) * HiW'(scale_i);
    hiy_d  = HiW'(vdy_q[VdW-1:VdLoW]) * HiW'(scale_i);
    dmag_d = DenW'(den_q[DenW-1] ? -den_q : den_q);
  end

  // stage 4: join partial products, quotient signs
  always_comb begin
    proj_d.num_x = NumW'(lox_q) + (NumW'(hix_q) << VdLoW);
    proj_d.num_y = NumW'(loy_q) + (NumW'(hiy_q) << VdLoW);
    proj_d.den   = dmag_q;
    proj_d.neg_x = posx3_q != dneg_q;
    proj_d.neg_y = posy3_q != dneg_q;
    proj_d.zero  = zero_q;
  end

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // data pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magx_q  <= magx_d;
      magy_q  <= magy_d;
      posx1_q <= posx_d;
      posy1_q <= posy_d;
      zp_q    <= zp_d;
      vdx_q   <= vdx_d;
      vdy_q   <= vdy_d;
      den_q   <= den_d;
      posx2_q <= posx1_q;
      posy2_q <= posy1_q;
      lox_q   <= lox_d;
      loy_q   <= loy_d;
      hix_q   <= hix_d;
      hiy_q   <= hiy_d;
      dmag_q  <= dmag_d;
      dneg_q  <= den_q[DenW-1];
      zero_q  <= den_q == '0;
      posx3_q <= posx2_q;
      posy3_q <= posy2_q;
      proj_q  <= proj_d;
    end
  end

  assign valid_o = vld_q[3];
  assign proj_o  = proj_q;

endmodule

// ===== rtl/rpv_divide.sv =====
// pipelined restoring divider for an x/y pair: one quotient bit per stage, then round
module rpv_divide import rpv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  proj_t    proj_i,
  output logic     valid_o,
  output div_res_t res_o
);

  localparam int unsigned LaneN = 2;
  localparam int unsigned CmpW  = DenW + QuotW;
  localparam int unsigned QW    = QuotW + 1;
  localparam logic [QW-1:0] LimitPos = {3'b000, {(OutW-1){1'b1}}};
  localparam logic [QW-1:0] LimitNeg = {3'b001, {(OutW-1){1'b0}}};

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [QuotW-1:0] quo;
    logic [QuotW-1:0] low;
    logic             big;
    logic             neg;
  } lane_t;

  lane_t           setup_d [LaneN];
  lane_t           step_d  [QuotW][LaneN];
  lane_t           lane_q  [QuotW+1][LaneN];
  logic [DenW-1:0] den_q   [QuotW+1];
  logic [QuotW:0]  zero_q;
  logic [QuotW:0]  vld_q;
  div_res_t        res_d, res_q;
  logic            vld_out_q;
  logic [OutW-1:0] fin_res [LaneN];
  logic            fin_sat [LaneN];

  // one restoring step: bring in the next numerator bit, subtract if it fits
  function automatic lane_t div_step(input lane_t cur, input logic [DenW-1:0] den);
    lane_t       nxt;
    logic [DenW:0] sh;
    logic        fit;
    sh       = {cur.rem, cur.low[QuotW-1]};
    fit      = sh >= {1'b0, den};
    nxt      = cur;
    nxt.rem  = fit ? DenW'(sh - {1'b0, den}) : DenW'(sh);
    nxt.quo  = {cur.quo[QuotW-2:0], fit};
    nxt.low  = {cur.low[QuotW-2:0], 1'b0};
    return nxt;
  endfunction

  // setup: overflow check against den shifted past the quotient, top bits as remainder
  always_comb begin
    logic [NumW-1:0] num;
    for (int l = 0; l < LaneN; l++) begin
      num             = (l == 0) ? proj_i.num_x : proj_i.num_y;
      setup_d[l].big  = CmpW'(num) >= {proj_i.den, QuotW'(0)};
      setup_d[l].rem  = DenW'(num >> QuotW);
      setup_d[l].low  = num[QuotW-1:0];
      setup_d[l].quo  = '0;
      setup_d[l].neg  = (l == 0) ? proj_i.neg_x : proj_i.neg_y;
    end
  end

  // quotient bit stages
  always_comb begin
    for (int s = 0; s < QuotW; s++) begin
      for (int l = 0; l < LaneN; l++) begin
        step_d[s][l] = div_step(lane_q[s][l], den_q[s]);
      end
    end
  end

  // round to nearest, ties away from zero, then clamp and apply sign
  always_comb begin
    logic [DenW:0]   twice;
    logic            up;
    logic [QW-1:0]   q1;
    logic [QW-1:0]   limit;
    logic [QW-1:0]   mag;
    for (int l = 0; l < LaneN; l++) begin
      twice      = {lane_q[QuotW][l].rem, 1'b0};
      up         = twice >= {1'b0, den_q[QuotW]};
      q1         = {1'b0, lane_q[QuotW][l].quo} + QW'(up);
      limit      = lane_q[QuotW][l].neg ? LimitNeg : LimitPos;
      fin_sat[l] = lane_q[QuotW][l].big || (q1 > limit);
      mag        = fin_sat[l] ? limit : q1;
      fin_res[l] = lane_q[QuotW][l].neg ? -mag[OutW-1:0] : mag[OutW-1:0];
    end
    res_d.zero  = zero_q[QuotW];
    res_d.res_x = zero_q[QuotW] ? '0 : fin_res[0];
    res_d.res_y = zero_q[QuotW] ? '0 : fin_res[1];
    res_d.sat   = !zero_q[QuotW] && (fin_sat[0] || fin_sat[1]);
  end

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[QuotW-1:0], valid_i};
      vld_out_q <= vld_q[QuotW];
    end
  end

  // data pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q[0] <= setup_d;
      den_q[0]  <= proj_i.den;
      zero_q    <= {zero_q[QuotW-1:0], proj_i.zero};
      for (int s = 0; s < QuotW; s++) begin
        lane_q[s+1] <= step_d[s];
        den_q[s+1]  <= den_q[s];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = vld_out_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/rotate_project_vertex_unit.sv =====
// top level: vertex rotation about z, x, y and near/far perspective projection
//
// Takes one signed Q8.8 vertex per clock and returns one result per vertex, in
// order, through the rotations, projection products, divider and output
// register; the divider (one quotient bit per stage, 33 stages) is the longest
// part. That rate holds whenever the output side takes results and the input
// is not held off. The user must write configuration through the cfg port
// only while no vertex is in flight; the block does not enforce it. Sine and
// cosine of the angles are looked up once per clock from the angle registers,
// so the vertex input is held off in the cycle after each register write.
module rotate_project_vertex_unit import rpv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // vertex input
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [3*VertW-1:0]    s_axis_tdata_i,   // vertex_x, vertex_y, vertex_z
  // projection output
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [4*OutW-1:0]     m_axis_tdata_o,   // near_x, near_y, far_x, far_y
  output logic [StatusW-1:0]    m_axis_tuser_o,   // status
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  logic en;
  logic in_vld;
  logic coef_wait_q;

  // configuration registers
  logic [AngleW-1:0] angle_x_q, angle_y_q, angle_z_q;
  logic [DistW-1:0]  dist_q;
  logic [ScaleW-1:0] scale_q, space_q;

  // derived coefficients
  logic signed [TrigW-1:0] cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
  logic [PW-1:0]           p_near_q, p_far_q;

  // rotation pipe
  logic                     vld_z, vld_x, vld_y;
  logic signed [CoordW-1:0] in_x, in_y, in_z;
  logic signed [CoordW-1:0] x1, y1, z0, y2, z2, x1p, x3, z3, y2p;

  // projection and divide
  logic     near_vld, far_vld, ndiv_vld, fdiv_vld;
  proj_t    near_proj, far_proj;
  div_res_t near_res, far_res;

  // output register
  logic                 m_valid_q;
  logic [4*OutW-1:0]    m_data_q;
  status_e              status_d, m_status_q;

  assign cfg_ready_o = 1'b1;

  // the whole pipe moves unless a finished result is held
  assign en              = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en && !coef_wait_q;
  assign in_vld          = s_axis_tvalid_i && !coef_wait_q;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
      dist_q    <= DistW'(2560);
      scale_q   <= ScaleW'(256);
      space_q   <= ScaleW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ANGLE_X:      angle_x_q <= cfg_data_i[AngleW-1:0];
        CFG_ANGLE_Y:      angle_y_q <= cfg_data_i[AngleW-1:0];
        CFG_ANGLE_Z:      angle_z_q <= cfg_data_i[AngleW-1:0];
        CFG_OBSERVER:     dist_q    <= cfg_data_i[DistW-1:0];
        CFG_SCALE:        scale_q   <= cfg_data_i[ScaleW-1:0];
        CFG_SPACE_LENGTH: space_q   <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // hold off the input while the coefficients catch up with a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_wait_q <= 1'b0;
    end else begin
      coef_wait_q <= cfg_valid_i;
    end
  end

  // coefficients follow the registers in the next cycle
  always_ff @(posedge clk_i) begin
    cos_x_q  <= cosine_of(angle_x_q);
    sin_x_q  <= sine_of(angle_x_q);
    cos_y_q  <= cosine_of(angle_y_q);
    sin_y_q  <= sine_of(angle_y_q);
    cos_z_q  <= cosine_of(angle_z_q);
    sin_z_q  <= sine_of(angle_z_q);
    p_near_q <= PW'({scale_q, FracBits'(0)});
    p_far_q  <= PW'(scale_q) * PW'(space_q);
  end

  // unpack and sign extend the vertex
  assign in_x = CoordW'($signed(s_axis_tdata_i[VertW-1:0]));
  assign in_y = CoordW'($signed(s_axis_tdata_i[2*VertW-1:VertW]));
  assign in_z = CoordW'($signed(s_axis_tdata_i[3*VertW-1:2*VertW]));

  // rotate about z
  rpv_rot_pair u_rot_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_vld),
    .a_i(in_x), .b_i(in_y), .pass_i(in_z), .cos_i(cos_z_q), .sin_i(sin_z_q),
    .valid_o(vld_z), .a_o(x1), .b_o(y1), .pass_o(z0)
  );

  // rotate about x
  rpv_rot_pair u_rot_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_z),
    .a_i(y1), .b_i(z0), .pass_i(x1), .cos_i(cos_x_q), .sin_i(sin_x_q),
    .valid_o(vld_x), .a_o(y2), .b_o(z2), .pass_o(x1p)
  );

  // rotate about y
  rpv_rot_pair u_rot_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_x),
    .a_i(x1p), .b_i(z2), .pass_i(y2), .cos_i(cos_y_q), .sin_i(sin_y_q),
    .valid_o(vld_y), .a_o(x3), .b_o(z3), .pass_o(y2p)
  );

  // near projection at the scale factor
  rpv_project u_proj_near (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_y),
    .x_i(x3), .y_i(y2p), .z_i(z3), .dist_i(dist_q), .scale_i(p_near_q),
    .valid_o(near_vld), .proj_o(near_proj)
  );

  // far projection at scale times space length
  rpv_project u_proj_far (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_y),
    .x_i(x3), .y_i(y2p), .z_i(z3), .dist_i(dist_q), .scale_i(p_far_q),
    .valid_o(far_vld), .proj_o(far_proj)
  );

  rpv_divide u_div_near (
    .clk_i, .rst_ni, .en_i(en), .valid_i(near_vld), .proj_i(near_proj),
    .valid_o(ndiv_vld), .res_o(near_res)
  );

  rpv_divide u_div_far (
    .clk_i, .rst_ni, .en_i(en), .valid_i(far_vld), .proj_i(far_proj),
    .valid_o(fdiv_vld), .res_o(far_res)
  );

  // status: zero denominator wins over saturation
  always_comb begin
    priority if (near_res.zero || far_res.zero) begin
      status_d = STATUS_ZERO_DEN;
    end else if (near_res.sat || far_res.sat) begin
      status_d = STATUS_SAT;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= ndiv_vld && fdiv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q   <= {far_res.res_y, far_res.res_x, near_res.res_y, near_res.res_x};
      m_status_q <= status_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;

endmodule
